// ----- hdl/conveyor_sort_station_controller_macros.svh -----
// Assertion macros shared by the conveyor sort station controller modules.
`ifndef CONVEYOR_SORT_STATION_CONTROLLER_MACROS_SVH
`define CONVEYOR_SORT_STATION_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on clk and disabled in reset.
`define CSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csc assertion failed");

// Next-cycle implication, checked on clk and disabled in reset.
`define CSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csc assertion failed");

`else

`define CSC_ASSERT_IMP(lbl, ante, cons)
`define CSC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/csc_pkg.sv -----
// Types, codes and constants of the conveyor sort station controller.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  // Controller modes.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PROC  = 2'd2,
    MODE_FAULT = 2'd3
  } mode_t;

  // Fault codes.
  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_ESTOP = 2'd1,
    FLT_SERVO = 2'd2
  } fault_t;

  // Conveyor commands.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  // Event bit positions.
  localparam int unsigned ESTOP_BIT  = 0;
  localparam int unsigned SERVO_BIT  = 1;
  localparam int unsigned RESET_BIT  = 2;
  localparam int unsigned STOP_BIT   = 3;
  localparam int unsigned START_BIT  = 4;
  localparam int unsigned DETECT_BIT = 5;
  localparam int unsigned DONE_BIT   = 6;
  localparam int unsigned CLEAR_BIT  = 7;

  localparam int unsigned EV_W  = 8;
  localparam int unsigned TS_W  = 32;
  localparam int unsigned LIM_W = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_DUTY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTUATOR   = 3'd4;

  // Register reset values.
  localparam logic [6:0]       RST_RUN_DUTY   = 7'd40;
  localparam logic [7:0]       RST_KICK_ANGLE = 8'd90;
  localparam logic [15:0]      RST_KICK_HOLD  = 16'd250;
  localparam logic [LIM_W-1:0] RST_BLOCKED    = 24'd10000;
  localparam logic [LIM_W-1:0] RST_ACTUATOR   = 24'd6000;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration register set.
  typedef struct packed {
    logic [6:0]       run_duty;
    logic [7:0]       kick_angle;
    logic [15:0]      kick_hold;
    logic [LIM_W-1:0] blocked_limit;
    logic [LIM_W-1:0] actuator_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic             drive_enabled;
    logic [EV_W-1:0]  consumed_events;
    logic [15:0]      kick_hold_out;
    logic [7:0]       kick_angle_out;
    logic             kick_issue;
    logic [6:0]       conveyor_duty;
    cmd_t             conveyor_cmd;
    fault_t           fault_code;
    mode_t            mode;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/csc_cfg_regs.sv -----
// Configuration registers of the conveyor sort station controller.
`timescale 1ns / 1ps
`default_nettype none

module csc_cfg_regs import csc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_duty       <= RST_RUN_DUTY;
      cfg.kick_angle     <= RST_KICK_ANGLE;
      cfg.kick_hold      <= RST_KICK_HOLD;
      cfg.blocked_limit  <= RST_BLOCKED;
      cfg.actuator_limit <= RST_ACTUATOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RUN_DUTY:   cfg.run_duty       <= cfg_data[6:0];
        CFG_KICK_ANGLE: cfg.kick_angle     <= cfg_data[7:0];
        CFG_KICK_HOLD:  cfg.kick_hold      <= cfg_data[15:0];
        CFG_BLOCKED:    cfg.blocked_limit  <= cfg_data[LIM_W-1:0];
        CFG_ACTUATOR:   cfg.actuator_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/csc_step.sv -----
// Controller state and the combinational step logic that updates it.
`timescale 1ns / 1ps
`default_nettype none

module csc_step import csc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step_en,
  input  wire logic [EV_W-1:0] new_events,
  input  wire logic [TS_W-1:0] now_ms,
  input  wire logic            sensor_present,
  input  wire cfg_t            cfg,
  output result_t              res
);

  `include "conveyor_sort_station_controller_macros.svh"

  // Controller state.
  logic [EV_W-1:0] pending;
  mode_t           mode_state;
  fault_t          fault_state;
  logic            interlock;
  logic [TS_W-1:0] detect_since;
  logic [TS_W-1:0] kick_sent;
  logic            done_latch;
  logic            clear_latch;

  logic [EV_W-1:0] pending_next;
  mode_t           mode_next;
  fault_t          fault_next;
  logic            interlock_next;
  logic [TS_W-1:0] detect_since_next;
  logic [TS_W-1:0] kick_sent_next;
  logic            done_latch_next;
  logic            clear_latch_next;

  logic [EV_W-1:0] ev;
  logic [EV_W-1:0] used;
  cmd_t            cmd;
  logic            kick;
  logic [TS_W-1:0] blocked_age;
  logic [TS_W-1:0] kick_age;
  logic            blocked_timeout;
  logic            kick_timeout;

  // Pending events merged with the newly raised ones.
  assign ev = pending | new_events;

  // Event handling in priority order.
  always_comb begin
    mode_next         = mode_state;
    fault_next        = fault_state;
    interlock_next    = interlock;
    detect_since_next = detect_since;
    kick_sent_next    = kick_sent;
    done_latch_next   = done_latch;
    clear_latch_next  = clear_latch;
    used              = '0;
    cmd               = CMD_NONE;
    kick              = 1'b0;
    blocked_age       = '0;
    kick_age          = '0;
    blocked_timeout   = 1'b0;
    kick_timeout      = 1'b0;

    if (mode_state == MODE_FAULT) begin
      cmd = CMD_STOP;
      if (ev[RESET_BIT]) begin
        interlock_next    = 1'b0;
        fault_next        = FLT_NONE;
        mode_next         = MODE_IDLE;
        used[RESET_BIT]   = 1'b1;
        detect_since_next = '0;
        kick_sent_next    = '0;
        done_latch_next   = 1'b0;
        clear_latch_next  = 1'b0;
      end else begin
        used            = ev;
        used[RESET_BIT] = 1'b0;
      end
    end else if (ev[ESTOP_BIT] || ev[SERVO_BIT]) begin
      interlock_next    = 1'b0;
      mode_next         = MODE_FAULT;
      cmd               = CMD_STOP;
      detect_since_next = '0;
      kick_sent_next    = '0;
      done_latch_next   = 1'b0;
      clear_latch_next  = 1'b0;
      if (ev[ESTOP_BIT]) begin
        fault_next      = FLT_ESTOP;
        used[ESTOP_BIT] = 1'b1;
      end else begin
        fault_next      = FLT_SERVO;
        used[SERVO_BIT] = 1'b1;
      end
    end else if (ev[RESET_BIT] || ev[STOP_BIT]) begin
      interlock_next    = 1'b0;
      mode_next         = MODE_IDLE;
      cmd               = CMD_STOP;
      detect_since_next = '0;
      kick_sent_next    = '0;
      done_latch_next   = 1'b0;
      clear_latch_next  = 1'b0;
      if (ev[RESET_BIT]) begin
        fault_next      = FLT_NONE;
        used[RESET_BIT] = 1'b1;
      end else begin
        used[STOP_BIT] = 1'b1;
      end
    end else if (ev[START_BIT] && (mode_state == MODE_IDLE)) begin
      interlock_next    = 1'b1;
      mode_next         = MODE_RUN;
      used[START_BIT]   = 1'b1;
      cmd               = CMD_SET;
      detect_since_next = '0;
      kick_sent_next    = '0;
      done_latch_next   = 1'b0;
      clear_latch_next  = 1'b0;
    end else if (ev[DETECT_BIT] && (mode_state == MODE_RUN)) begin
      mode_next         = MODE_PROC;
      used[DETECT_BIT]  = 1'b1;
      cmd               = CMD_STOP;
      kick              = 1'b1;
      detect_since_next = now_ms;
      kick_sent_next    = now_ms;
      done_latch_next   = 1'b0;
      clear_latch_next  = 1'b0;
    end else if (mode_state == MODE_PROC) begin
      // Latch done and clear, then let the sensor level override clear.
      if (ev[DONE_BIT]) begin
        used[DONE_BIT]  = 1'b1;
        done_latch_next = 1'b1;
      end
      if (ev[CLEAR_BIT]) begin
        used[CLEAR_BIT]   = 1'b1;
        clear_latch_next  = 1'b1;
        detect_since_next = '0;
      end
      if (sensor_present) begin
        clear_latch_next = 1'b0;
        if (detect_since_next == '0) begin
          detect_since_next = now_ms;
        end
      end
      // Elapsed times with wrapping subtraction, taken from the stamps as updated above.
      blocked_age     = now_ms - detect_since_next;
      kick_age        = now_ms - kick_sent;
      blocked_timeout = (detect_since_next != '0) && sensor_present &&
                        (blocked_age > {{(TS_W-LIM_W){1'b0}}, cfg.blocked_limit});
      kick_timeout    = (kick_sent != '0) && !done_latch_next &&
                        (kick_age > {{(TS_W-LIM_W){1'b0}}, cfg.actuator_limit});
      if (done_latch_next && clear_latch_next) begin
        if (interlock) begin
          mode_next = MODE_RUN;
          cmd       = CMD_SET;
        end else begin
          mode_next = MODE_IDLE;
          cmd       = CMD_STOP;
        end
        detect_since_next = '0;
        kick_sent_next    = '0;
        done_latch_next   = 1'b0;
        clear_latch_next  = 1'b0;
      end else if (blocked_timeout) begin
        mode_next         = MODE_FAULT;
        fault_next        = FLT_SERVO;
        detect_since_next = '0;
        kick_sent_next    = '0;
      end else if (kick_timeout) begin
        mode_next      = MODE_FAULT;
        fault_next     = FLT_SERVO;
        kick_sent_next = '0;
      end
    end

    pending_next = ev & ~used;
  end

  // Result fields for this step.
  always_comb begin
    res.mode            = mode_next;
    res.fault_code      = fault_next;
    res.conveyor_cmd    = cmd;
    res.conveyor_duty   = (cmd == CMD_SET) ? cfg.run_duty : '0;
    res.kick_issue      = kick;
    res.kick_angle_out  = kick ? cfg.kick_angle : '0;
    res.kick_hold_out   = kick ? cfg.kick_hold : '0;
    res.consumed_events = used;
    res.drive_enabled   = interlock_next;
  end

  // State update, one step per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      mode_state   <= MODE_IDLE;
      fault_state  <= FLT_NONE;
      interlock    <= 1'b0;
      detect_since <= '0;
      kick_sent    <= '0;
      done_latch   <= 1'b0;
      clear_latch  <= 1'b0;
    end else if (step_en) begin
      pending      <= pending_next;
      mode_state   <= mode_next;
      fault_state  <= fault_next;
      interlock    <= interlock_next;
      detect_since <= detect_since_next;
      kick_sent    <= kick_sent_next;
      done_latch   <= done_latch_next;
      clear_latch  <= clear_latch_next;
    end
  end

  // Fault mode and a fault code always go together.
  `CSC_ASSERT_IMP(a_fault_pairs, 1'b1, (mode_state == MODE_FAULT) == (fault_state != FLT_NONE))
  // Only events that were pending or just raised can be consumed.
  `CSC_ASSERT_IMP(a_used_subset, step_en, (used & ~ev) == '0)
  // A kick is only issued on entry to processing with the conveyor stopped.
  `CSC_ASSERT_IMP(a_kick_entry, step_en && kick,
                  (mode_state == MODE_RUN) && (mode_next == MODE_PROC) && (cmd == CMD_STOP))
  // Consumed events leave the pending set at the next edge.
  `CSC_ASSERT_NXT(a_pending_cleared, step_en && (used != '0), (pending & $past(used)) == '0)

endmodule

`default_nettype wire

// ----- hdl/conveyor_sort_station_controller.sv -----
// Top level of the conveyor sort station controller: stream stages and configuration.
// The controller takes one event item per clock while the result side is not stalling and
// returns one result item for each, registered first in the input register and then in the
// result register. The whole step, including both timeout subtract-and-compare paths,
// runs between those two registers, and the controller state closes its loop through
// that single step for each item. Stalls on the result side hold both stages in place.
`timescale 1ns / 1ps
`default_nettype none

module conveyor_sort_station_controller import csc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // new_events[7:0], now_ms[39:8], sensor_present[40]
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // mode[1:0], fault_code[3:2], conveyor_cmd[5:4],
                                                // conveyor_duty[12:6], kick_issue[13],
                                                // kick_angle_out[21:14], kick_hold_out[37:22],
                                                // consumed_events[45:38], drive_enabled[46]
  // Configuration writes.
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "conveyor_sort_station_controller_macros.svh"

  cfg_t            cfg;
  result_t         res;
  logic            in_valid;
  logic [EV_W-1:0] in_events;
  logic [TS_W-1:0] in_now;
  logic            in_present;
  logic            advance;
  logic            step_en;

  // The result register can take a new item when empty or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign step_en  = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_events  <= s_tdata[7:0];
      in_now     <= s_tdata[39:8];
      in_present <= s_tdata[40];
    end
  end

  csc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  csc_step u_step (
    .clk            (clk),
    .rst            (rst),
    .step_en        (step_en),
    .new_events     (in_events),
    .now_ms         (in_now),
    .sensor_present (in_present),
    .cfg            (cfg),
    .res            (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      m_tdata <= {1'b0, res};
    end
  end

  // A stepped item always shows up as a result in the next cycle.
  `CSC_ASSERT_NXT(a_step_to_result, step_en, m_tvalid)
  // The input stage never drops an item while the result side stalls.
  `CSC_ASSERT_NXT(a_hold_input, in_valid && !advance, in_valid)

endmodule

`default_nettype wire

// ----- dv/conveyor_sort_station_controller_tb.sv -----
// Self-checking testbench for the conveyor sort station controller with an inline predictor.
`timescale 1ns / 1ps

module conveyor_sort_station_controller_tb;
  import csc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD = 150;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;   // new_events[7:0], now_ms[39:8], sensor_present[40]
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;  // result_t fields from mode up to drive_enabled
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  conveyor_sort_station_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus feed, awaited station status and run bookkeeping.
  logic [IN_DATA_W-1:0] item_feed_q[$];
  result_t awaited_status_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned items_queued;
  logic [31:0] tick_ms;
  int unsigned tick_step_max;
  bit quiet;
  bit long_hold_req;
  bit long_hold_done;
  int unsigned hold_left;
  bit offer_taken;

  // Predictor copy of the configuration registers.
  logic [6:0] c_duty;
  logic [7:0] c_angle;
  logic [15:0] c_hold;
  logic [LIM_W-1:0] c_blocked;
  logic [LIM_W-1:0] c_actuator;

  // Predictor copy of the controller state.
  logic [EV_W-1:0] p_pending;
  mode_t p_mode;
  fault_t p_fault;
  logic p_interlock;
  logic [31:0] p_detect_ts;
  logic [31:0] p_kick_ts;
  logic p_done_seen;
  logic p_clear_seen;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [EV_W-1:0] ev_mask(input int unsigned pos);
    ev_mask = EV_W'(1) << pos;
  endfunction

  function automatic void drop_tracking();
    p_detect_ts = '0;
    p_kick_ts = '0;
    p_done_seen = 1'b0;
    p_clear_seen = 1'b0;
  endfunction

  // One controller step: merge events, run the mode logic, build the status item.
  function automatic result_t sort_station_step(input logic [EV_W-1:0] raised,
                                                input logic [31:0] now,
                                                input logic present);
    logic [EV_W-1:0] ev;
    logic [EV_W-1:0] used;
    logic [31:0] age;
    cmd_t cmd;
    logic kick;
    result_t r;
    used = '0;
    cmd = CMD_NONE;
    kick = 1'b0;
    p_pending = p_pending | raised;
    ev = p_pending;
    if (p_mode == MODE_FAULT) begin
      // Only a reset leaves fault; anything else is swallowed.
      if (ev[RESET_BIT]) begin
        p_interlock = 1'b0;
        p_fault = FLT_NONE;
        p_mode = MODE_IDLE;
        used = ev_mask(RESET_BIT);
        drop_tracking();
      end else begin
        used = ev;
        used[RESET_BIT] = 1'b0;
      end
      cmd = CMD_STOP;
    end else if (ev[ESTOP_BIT] || ev[SERVO_BIT]) begin
      p_interlock = 1'b0;
      p_mode = MODE_FAULT;
      if (ev[ESTOP_BIT]) begin
        p_fault = FLT_ESTOP;
        used = ev_mask(ESTOP_BIT);
      end else begin
        p_fault = FLT_SERVO;
        used = ev_mask(SERVO_BIT);
      end
      cmd = CMD_STOP;
      drop_tracking();
    end else if (ev[RESET_BIT] || ev[STOP_BIT]) begin
      p_interlock = 1'b0;
      p_mode = MODE_IDLE;
      if (ev[RESET_BIT]) begin
        p_fault = FLT_NONE;
        used = ev_mask(RESET_BIT);
      end else begin
        used = ev_mask(STOP_BIT);
      end
      cmd = CMD_STOP;
      drop_tracking();
    end else if (ev[START_BIT] && p_mode == MODE_IDLE) begin
      p_interlock = 1'b1;
      p_mode = MODE_RUN;
      used = ev_mask(START_BIT);
      drop_tracking();
      cmd = CMD_SET;
    end else if (ev[DETECT_BIT] && p_mode == MODE_RUN) begin
      p_mode = MODE_PROC;
      used = ev_mask(DETECT_BIT);
      cmd = CMD_STOP;
      kick = 1'b1;
      p_detect_ts = now;
      p_kick_ts = now;
      p_done_seen = 1'b0;
      p_clear_seen = 1'b0;
    end else if (p_mode == MODE_PROC) begin
      // Latch done and clear, then either release the item or check both timers.
      if (ev[DONE_BIT]) begin
        used[DONE_BIT] = 1'b1;
        p_done_seen = 1'b1;
      end
      if (ev[CLEAR_BIT]) begin
        used[CLEAR_BIT] = 1'b1;
        p_clear_seen = 1'b1;
        p_detect_ts = '0;
      end
      if (present) begin
        p_clear_seen = 1'b0;
        if (p_detect_ts == 0) p_detect_ts = now;
      end
      if (p_done_seen && p_clear_seen) begin
        if (p_interlock) begin
          p_mode = MODE_RUN;
          cmd = CMD_SET;
        end else begin
          p_mode = MODE_IDLE;
          cmd = CMD_STOP;
        end
        drop_tracking();
      end else begin
        age = now - p_detect_ts;
        if (p_detect_ts != 0 && present && age > {8'd0, c_blocked}) begin
          p_mode = MODE_FAULT;
          p_fault = FLT_SERVO;
          p_detect_ts = '0;
          p_kick_ts = '0;
        end
        age = now - p_kick_ts;
        if (p_mode == MODE_PROC && p_kick_ts != 0 && !p_done_seen &&
            age > {8'd0, c_actuator}) begin
          p_mode = MODE_FAULT;
          p_fault = FLT_SERVO;
          p_kick_ts = '0;
        end
      end
    end
    p_pending = p_pending & ~used;

    r.mode = p_mode;
    r.fault_code = p_fault;
    r.conveyor_cmd = cmd;
    r.conveyor_duty = (cmd == CMD_SET) ? c_duty : 7'd0;
    r.kick_issue = kick;
    r.kick_angle_out = kick ? c_angle : 8'd0;
    r.kick_hold_out = kick ? c_hold : 16'd0;
    r.consumed_events = used;
    r.drive_enabled = p_interlock;
    return r;
  endfunction

  // Accept side: a transfer on the input stream is predicted at the same edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      awaited_status_q.push_back(sort_station_step(s_tdata[7:0], s_tdata[39:8], s_tdata[40]));
      void'(item_feed_q.pop_front());
      offer_taken = 1'b1;
    end
  end

  // Offer side: hold an unaccepted item, otherwise present the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !offer_taken) begin
      s_tvalid <= 1'b1;
    end else if (item_feed_q.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
      s_tvalid <= 1'b1;
      s_tdata <= item_feed_q[0];
    end else begin
      s_tvalid <= 1'b0;
    end
    offer_taken = 1'b0;
  end

  // Result side readiness, with one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, seen);
      fail_count++;
    end
  endtask

  // Compare each result transfer with the oldest awaited status.
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[$bits(result_t)-1:0];
      if (awaited_status_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %0h", $time, m_tdata);
        fail_count++;
      end else begin
        want = awaited_status_q.pop_front();
        check_field("mode", want.mode, seen.mode);
        check_field("fault_code", want.fault_code, seen.fault_code);
        check_field("conveyor_cmd", want.conveyor_cmd, seen.conveyor_cmd);
        check_field("conveyor_duty", want.conveyor_duty, seen.conveyor_duty);
        check_field("kick_issue", want.kick_issue, seen.kick_issue);
        check_field("kick_angle_out", want.kick_angle_out, seen.kick_angle_out);
        check_field("kick_hold_out", want.kick_hold_out, seen.kick_hold_out);
        check_field("consumed_events", want.consumed_events, seen.consumed_events);
        check_field("drive_enabled", want.drive_enabled, seen.drive_enabled);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(input logic [EV_W-1:0] ev, input logic [31:0] now,
                           input logic present);
    item_feed_q.push_back({7'd0, present, now, ev});
    items_queued++;
  endtask

  // Queue an item at the running millisecond tick, advancing it first.
  task automatic push_timed(input logic [EV_W-1:0] ev, input logic present);
    tick_ms = tick_ms + $urandom_range(tick_step_max);
    push_item(ev, tick_ms, present);
  endtask

  // Write one register and mirror it in the predictor copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RUN_DUTY:   c_duty = val[6:0];
      CFG_KICK_ANGLE: c_angle = val[7:0];
      CFG_KICK_HOLD:  c_hold = val[15:0];
      CFG_BLOCKED:    c_blocked = val;
      CFG_ACTUATOR:   c_actuator = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (item_feed_q.size() != 0 || awaited_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One sorting cycle: start, detect, then done/clear traffic with the sensor level.
  task automatic sort_cycle();
    int unsigned n;
    logic [EV_W-1:0] ev;
    if ($urandom_range(2) == 0) push_timed(ev_mask(RESET_BIT), 1'b0);
    push_timed(ev_mask(START_BIT), 1'b0);
    push_timed(ev_mask(DETECT_BIT), $urandom_range(1));
    n = $urandom_range(1, 6);
    repeat (n) begin
      ev = '0;
      if ($urandom_range(99) < 40) ev[DONE_BIT] = 1'b1;
      if ($urandom_range(99) < 40) ev[CLEAR_BIT] = 1'b1;
      push_timed(ev, $urandom_range(99) < 30);
    end
    if ($urandom_range(99) < 15) push_timed(ev_mask(STOP_BIT), 1'b0);
  endtask

  // Noise: single random events, random bytes and jumps of the tick.
  task automatic noise_item();
    logic [EV_W-1:0] ev;
    if ($urandom_range(3) == 0) tick_ms = $urandom();
    if ($urandom_range(1) == 0) ev = ev_mask($urandom_range(EV_W - 1));
    else ev = $urandom_range(255);
    push_timed(ev, $urandom_range(1));
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    goal = items_queued + count;
    while (items_queued < goal) begin
      if ($urandom_range(99) < 75) sort_cycle();
      else noise_item();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    items_queued = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    hold_left = 0;
    offer_taken = 1'b0;
    tick_ms = 32'd100;
    tick_step_max = 20;
    c_duty = RST_RUN_DUTY;
    c_angle = RST_KICK_ANGLE;
    c_hold = RST_KICK_HOLD;
    c_blocked = RST_BLOCKED;
    c_actuator = RST_ACTUATOR;
    p_pending = '0;
    p_mode = MODE_IDLE;
    p_fault = FLT_NONE;
    p_interlock = 1'b0;
    drop_tracking();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk at the reset register values.
    push_item('0, 32'd0, 1'b0);
    push_item(ev_mask(DETECT_BIT), 32'd1, 1'b0);      // detect in idle stays pending
    push_item(ev_mask(START_BIT), 32'd2, 1'b0);
    push_item('0, 32'd3, 1'b0);                        // pending detect kicks
    push_item(ev_mask(START_BIT), 32'd4, 1'b0);       // start outside idle stays pending
    push_item(ev_mask(DONE_BIT), 32'd5, 1'b1);
    push_item(ev_mask(CLEAR_BIT), 32'd6, 1'b0);       // both latched, back to run
    push_item(ev_mask(DETECT_BIT), 32'd0, 1'b0);      // detect at tick zero leaves stamps unset
    push_item('0, 32'd20000, 1'b1);
    push_item('0, 32'd30001, 1'b1);                    // blocked too long
    push_item(ev_mask(START_BIT) | ev_mask(DETECT_BIT) | ev_mask(DONE_BIT), 32'd30002, 1'b0);
    push_item(ev_mask(RESET_BIT), 32'd30003, 1'b0);
    push_item(ev_mask(START_BIT), 32'd40000, 1'b0);
    push_item(ev_mask(DETECT_BIT), 32'd40001, 1'b0);
    push_item('0, 32'd46002, 1'b0);                    // actuator answered too late
    push_item(ev_mask(RESET_BIT) | ev_mask(ESTOP_BIT), 32'd46003, 1'b0);
    push_item('0, 32'd46004, 1'b0);                    // leftover estop takes effect
    push_item(ev_mask(RESET_BIT), 32'd46005, 1'b0);
    push_item(ev_mask(SERVO_BIT) | ev_mask(STOP_BIT), 32'd46006, 1'b0);
    push_item(ev_mask(RESET_BIT), 32'd46007, 1'b0);
    push_item(ev_mask(STOP_BIT), 32'd46008, 1'b0);
    push_item(8'hFF, 32'hFFFF_FFFF, 1'b1);
    push_item(ev_mask(RESET_BIT), 32'hFFFF_FFFF, 1'b0);
    wait_drained();

    // Largest outputs, zero limits: any elapsed tick times out.
    write_reg(CFG_RUN_DUTY, 24'd100);
    write_reg(CFG_KICK_ANGLE, 24'd180);
    write_reg(CFG_KICK_HOLD, 24'd65535);
    write_reg(CFG_BLOCKED, 24'd0);
    write_reg(CFG_ACTUATOR, 24'd0);
    end_writes();
    tick_step_max = 3;
    random_phase(170);

    // Zero outputs, largest limits, tick wrapping through zero; unused indexes ignored.
    write_reg(CFG_RUN_DUTY, 24'd0);
    write_reg(CFG_KICK_ANGLE, 24'd0);
    write_reg(CFG_KICK_HOLD, 24'd0);
    write_reg(CFG_BLOCKED, 24'hFF_FFFF);
    write_reg(CFG_ACTUATOR, 24'hFF_FFFF);
    write_reg(3'd5, 24'hFF_FFFF);
    write_reg(3'd6, 24'h5A_5A5A);
    write_reg(3'd7, 24'hA5_A5A5);
    end_writes();
    tick_ms = 32'hFFFF_F000;
    tick_step_max = 1000;
    random_phase(170);

    // Duty above the percent range, short limits, no idling on either side.
    write_reg(CFG_RUN_DUTY, 24'd127);
    write_reg(CFG_KICK_ANGLE, $urandom_range(180));
    write_reg(CFG_KICK_HOLD, $urandom_range(65535));
    write_reg(CFG_BLOCKED, 24'd40);
    write_reg(CFG_ACTUATOR, 24'd25);
    end_writes();
    quiet = 1'b1;
    tick_step_max = 15;
    random_phase(200);
    quiet = 1'b0;

    // Random settings; the result side holds off long enough to back up the input.
    write_reg(CFG_RUN_DUTY, $urandom_range(127));
    write_reg(CFG_KICK_ANGLE, $urandom());
    write_reg(CFG_KICK_HOLD, $urandom_range(65535));
    write_reg(CFG_BLOCKED, $urandom_range(300));
    write_reg(CFG_ACTUATOR, $urandom_range(300));
    end_writes();
    long_hold_req = 1'b1;
    tick_step_max = 60;
    random_phase(200);

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
